// File: rtl/shs_pkg.sv
// Package for the SHA-256 stream hasher: word types, command codes, round
// constants, initial hash values and the sigma functions. No dependencies.
package shs_pkg;

    typedef logic [7:0][31:0] t_words8;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_ROUND = 5'b00100,
        S_ADD   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    localparam logic        CMD_DATA    = 1'b0;
    localparam logic        CMD_FINISH  = 1'b1;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned HASH_WORDS  = 8;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    localparam logic [5:0]  LEN_OFFSET  = 6'd56;
    localparam logic [63:0] BLOCK_BITS  = 64'd512;

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV_TABLE [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// File: rtl/shs_round.sv
// One SHA-256 compression round on the eight working variables.
// Depends on shs_pkg.
module shs_round (
    input  shs_pkg::t_words8 i_v,
    input  logic [31:0]      i_w,
    input  logic [31:0]      i_k,
    output shs_pkg::t_words8 o_v
);
    import shs_pkg::*;

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    always_comb begin
        ch  = (i_v[4] & i_v[5]) ^ (~i_v[4] & i_v[6]);
        maj = (i_v[0] & i_v[1]) ^ (i_v[0] & i_v[2]) ^ (i_v[1] & i_v[2]);
        t1  = i_v[7] + bsig1(i_v[4]) + ch + i_k + i_w;
        t2  = bsig0(i_v[0]) + maj;
        o_v[0] = t1 + t2;
        o_v[1] = i_v[0];
        o_v[2] = i_v[1];
        o_v[3] = i_v[2];
        o_v[4] = i_v[3] + t1;
        o_v[5] = i_v[4];
        o_v[6] = i_v[5];
        o_v[7] = i_v[6];
    end

endmodule

// File: rtl/sha256_stream_hasher.sv
// SHA-256 stream hasher top level: block buffer and hash memories, schedule
// window, padding and digest output. Depends on shs_pkg and shs_round.
//
// channel | dir | fields
// s       | in  | tdata[7:0] msg_byte, tuser cmd (1 = finish)
// m       | out | tdata[31:0] digest_word, tdata[34:32] word_index, tlast last_word
//
// A message byte is taken while the hasher is idle; the 64th byte of a
// block starts a compression (hash load, 64 rounds, add/writeback).
// A finish runs one or two compressions, then reads the hash memory
// one word at a time, each read issued while the output register is free.
// Reset clears control state; the hash memory reads as the initial values
// until the first compression writes it back, so no clearing pass is needed.
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] msg_byte
    input  logic        i_s_tuser,   // [0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        o_m_tlast    // last_word
);
    import shs_pkg::*;

    t_state      r_state;
    logic [5:0]  r_cnt;
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [63:0] r_len;
    logic [31:0] r_acc;
    logic        r_fresh;

    logic [4:0]  r_nw;
    logic [31:0] r_tail;
    logic        r_tail_en;
    logic        r_len_en;
    logic        r_pad2;
    logic        r_fin;

    logic [31:0] r_bmem [BLOCK_WORDS];
    logic [31:0] r_brd;
    logic [31:0] r_hmem [HASH_WORDS];
    logic [31:0] r_hrd;
    logic [2:0]  r_hrd_addr;

    t_words8     r_v;
    t_words8     n_v;
    logic [31:0] r_w [BLOCK_WORDS];

    logic [2:0]  r_oidx;
    logic        r_rd_pend;
    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic [2:0]  r_out_idx;
    logic        r_out_last;

    logic        in_acc;
    logic        out_acc;
    logic        issue;
    logic [3:0]  b_raddr;
    logic [2:0]  h_raddr;
    logic [2:0]  cnt_m1;
    logic [31:0] hval;
    logic [31:0] w_sched;
    logic [31:0] w_t;
    logic [31:0] tail;
    logic [31:0] acc_next;

    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_acc    = r_out_valid && i_m_tready;
    assign issue      = (r_state == S_OUT) && !r_rd_pend && (!r_out_valid || i_m_tready);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_idx, r_out_word};
    assign o_m_tlast  = r_out_last;

    assign cnt_m1  = r_cnt[2:0] - 3'd1;
    assign b_raddr = (r_state == S_ROUND) ? (r_cnt[3:0] + 4'd1) : 4'd0;
    assign h_raddr = (r_state == S_OUT) ? r_oidx : r_cnt[2:0];
    assign hval    = r_fresh ? IV_TABLE[r_hrd_addr] : r_hrd;

    always_comb begin
        unique case (r_fill[1:0])
            2'd0: tail = {PAD_BYTE, 24'd0};
            2'd1: tail = {r_acc[31:24], PAD_BYTE, 16'd0};
            2'd2: tail = {r_acc[31:16], PAD_BYTE, 8'd0};
            2'd3: tail = {r_acc[31:8], PAD_BYTE};
            default: tail = '0;
        endcase
        unique case (r_fill[1:0])
            2'd0: acc_next = {i_s_tdata, r_acc[23:0]};
            2'd1: acc_next = {r_acc[31:24], i_s_tdata, r_acc[15:0]};
            2'd2: acc_next = {r_acc[31:16], i_s_tdata, r_acc[7:0]};
            2'd3: acc_next = {r_acc[31:8], i_s_tdata};
            default: acc_next = r_acc;
        endcase
    end

    always_comb begin
        w_sched = ssig1(r_w[14]) + r_w[9] + ssig0(r_w[1]) + r_w[0];
        priority if (r_cnt[5:4] != 2'd0) begin
            w_t = w_sched;
        end else if ({1'b0, r_cnt[3:0]} < r_nw) begin
            w_t = r_brd;
        end else if (r_tail_en && ({1'b0, r_cnt[3:0]} == r_nw)) begin
            w_t = r_tail;
        end else if (r_len_en && (r_cnt[3:0] == 4'd14)) begin
            w_t = r_len[63:32];
        end else if (r_len_en && (r_cnt[3:0] == 4'd15)) begin
            w_t = r_len[31:0];
        end else begin
            w_t = '0;
        end
    end

    shs_round u_round (
        .i_v (r_v),
        .i_w (w_t),
        .i_k (K_TABLE[r_cnt]),
        .o_v (n_v)
    );

    // block buffer memory
    always_ff @(posedge i_clk) begin
        if (in_acc && !i_s_tuser && (r_fill[1:0] == 2'd3)) begin
            r_bmem[r_fill[5:2]] <= acc_next;
        end
        r_brd <= r_bmem[b_raddr];
    end

    // hash memory
    always_ff @(posedge i_clk) begin
        if ((r_state == S_ADD) && (r_cnt != 6'd0)) begin
            r_hmem[cnt_m1] <= hval + r_v[cnt_m1];
        end
        r_hrd      <= r_hmem[h_raddr];
        r_hrd_addr <= h_raddr;
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc && !i_s_tuser) begin
            r_acc <= acc_next;
        end
        if ((r_state == S_LOAD) && (r_cnt != 6'd0)) begin
            r_v[cnt_m1] <= hval;
        end
        if (r_state == S_ROUND) begin
            r_v <= n_v;
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[BLOCK_WORDS - 1] <= w_t;
        end
        if (r_rd_pend) begin
            r_out_word <= hval;
            r_out_idx  <= r_oidx;
            r_out_last <= (r_oidx == 3'd7);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_fill      <= '0;
            r_bits      <= '0;
            r_len       <= '0;
            r_fresh     <= 1'b1;
            r_nw        <= 5'd16;
            r_tail      <= '0;
            r_tail_en   <= 1'b0;
            r_len_en    <= 1'b0;
            r_pad2      <= 1'b0;
            r_fin       <= 1'b0;
            r_oidx      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cnt <= '0;
                        if (i_s_tuser) begin
                            r_len     <= r_bits + {55'd0, r_fill, 3'd0};
                            r_nw      <= {1'b0, r_fill[5:2]};
                            r_tail    <= tail;
                            r_tail_en <= 1'b1;
                            r_len_en  <= (r_fill < LEN_OFFSET);
                            r_pad2    <= (r_fill >= LEN_OFFSET);
                            r_fin     <= 1'b1;
                            r_fill    <= '0;
                            r_bits    <= '0;
                            r_state   <= S_LOAD;
                        end else begin
                            r_fill <= r_fill + 6'd1;
                            if (r_fill == 6'd63) begin
                                r_bits    <= r_bits + BLOCK_BITS;
                                r_nw      <= 5'd16;
                                r_tail_en <= 1'b0;
                                r_len_en  <= 1'b0;
                                r_pad2    <= 1'b0;
                                r_fin     <= 1'b0;
                                r_state   <= S_LOAD;
                            end
                        end
                    end
                end
                S_LOAD: begin
                    if (r_cnt == 6'd8) begin
                        r_cnt   <= '0;
                        r_state <= S_ROUND;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_ROUND: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    if (r_cnt == 6'd8) begin
                        r_cnt   <= '0;
                        r_fresh <= 1'b0;
                        if (r_pad2) begin
                            r_pad2    <= 1'b0;
                            r_nw      <= 5'd0;
                            r_tail_en <= 1'b0;
                            r_len_en  <= 1'b1;
                            r_state   <= S_LOAD;
                        end else if (r_fin) begin
                            r_oidx  <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_OUT: begin
                    if (issue) begin
                        r_rd_pend <= 1'b1;
                    end
                    if (r_rd_pend) begin
                        r_rd_pend   <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_oidx      <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_fresh <= 1'b1;
                            r_fin   <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_round_to_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) && (r_cnt == 6'd63) |=> (r_state == S_ADD))
        else $error("round count did not end in add phase");

    a_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_s_tuser && (r_fill == 6'd63) |=> (r_state == S_LOAD) && (r_fill == 6'd0))
        else $error("full block did not start compression");

    a_finish_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_s_tuser |=> (r_fill == 6'd0) && (r_bits == 64'd0) && r_fin)
        else $error("finish did not clear length state");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_last == (r_out_idx == 3'd7)))
        else $error("last marker does not match word index");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend && r_out_valid |-> i_m_tready || !$past(r_out_valid))
        else $error("digest word captured over a pending word");

endmodule
